/* hw/rtl/bfpg_pkg.sv */
package bfpg_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Microcode program counter width
  localparam int unsigned PC_W = 6;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_X_SCALE     = 3'd0,
    CFG_X_OFFSET    = 3'd1,
    CFG_Y_SCALE     = 3'd2,
    CFG_Y_OFFSET    = 3'd3,
    CFG_COS_TERM    = 3'd4,
    CFG_SIN_TERM    = 3'd5,
    CFG_PIXEL_COLOR = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0] rand_pick;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        in_bounds;
    logic [23:0] color_out;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x_scale;
    logic signed [31:0] x_offset;
    logic signed [31:0] y_scale;
    logic signed [31:0] y_offset;
    logic signed [17:0] cos_term;
    logic signed [17:0] sin_term;
    logic        [23:0] pixel_color;
  } cfg_t;

  // Which fern map a pick selects
  typedef enum logic [1:0] {
    CLS_STEM,
    CLS_MAIN,
    CLS_LEFT,
    CLS_RIGHT
  } pick_cls_e;

  // Multiplier operand A
  typedef enum logic [3:0] {
    A_NONE,
    A_PX,
    A_PY,
    A_XOFF,
    A_YOFF,
    A_ONE,
    A_DXH,
    A_DXL,
    A_DYH,
    A_DYL
  } a_sel_e;

  // Multiplier operand B
  typedef enum logic [4:0] {
    B_C016,
    B_C085,
    B_C004,
    B_C160,
    B_C020,
    B_C026,
    B_C023,
    B_C022,
    B_C015,
    B_C028,
    B_C024,
    B_C044,
    B_ONE,
    B_XSCALE,
    B_YSCALE,
    B_COS,
    B_SIN
  } b_sel_e;

  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_NLOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_CLR
  } acc_op_e;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_NX,
    WB_NY,
    WB_DX,
    WB_DY,
    WB_RX
  } wb_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_GOTO,
    SEQ_DISPATCH,
    SEQ_DONE
  } seq_e;

  typedef struct packed {
    a_sel_e          a_sel;
    b_sel_e          b_sel;
    logic            shift24;
    acc_op_e         acc_op;
    wb_e             wb;
    seq_e            seq;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic       en;
    logic       done;
    ctrl_word_t word;
  } seq_ctrl_t;

  // Q.24 map coefficients, rounded to nearest
  localparam logic signed [32:0] C016  = 33'sd2684355;
  localparam logic signed [32:0] C085  = 33'sd14260634;
  localparam logic signed [32:0] C004  = 33'sd671089;
  localparam logic signed [32:0] C160  = 33'sd26843546;
  localparam logic signed [32:0] C020  = 33'sd3355443;
  localparam logic signed [32:0] C026  = 33'sd4362076;
  localparam logic signed [32:0] C023  = 33'sd3858760;
  localparam logic signed [32:0] C022  = 33'sd3690988;
  localparam logic signed [32:0] C015  = 33'sd2516582;
  localparam logic signed [32:0] C028  = 33'sd4697620;
  localparam logic signed [32:0] C024  = 33'sd4026532;
  localparam logic signed [32:0] C044  = 33'sd7381975;
  localparam logic signed [32:0] K_ONE = 33'sd16777216;

  // Program entry points
  localparam logic [PC_W-1:0] ADDR_DISPATCH = 6'd0;
  localparam logic [PC_W-1:0] ADDR_STEM     = 6'd1;
  localparam logic [PC_W-1:0] ADDR_MAIN     = 6'd5;
  localparam logic [PC_W-1:0] ADDR_LEFT     = 6'd12;
  localparam logic [PC_W-1:0] ADDR_RIGHT    = 6'd19;
  localparam logic [PC_W-1:0] ADDR_PIXEL    = 6'd26;

  function automatic ctrl_word_t uw(input a_sel_e a, input b_sel_e b, input logic sh,
                                    input acc_op_e op, input wb_e wb, input seq_e sq);
    ctrl_word_t w;
    w.a_sel   = a;
    w.b_sel   = b;
    w.shift24 = sh;
    w.acc_op  = op;
    w.wb      = wb;
    w.seq     = sq;
    w.target  = ADDR_PIXEL;
    return w;
  endfunction

  // Microcode program. Each step that selects an operand A issues one product into the product register,
  // applies the accumulator op to the product issued by the previous step, and
  // writes back from the accumulator value as it stood at the start of the step.
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = uw(A_NONE, B_ONE, 1'b0, ACC_NOP, WB_NONE, SEQ_DONE);
    case (pc)
      ADDR_DISPATCH:      w = uw(A_NONE, B_ONE,  1'b0, ACC_NOP,   WB_NONE, SEQ_DISPATCH);
      // stem: nx = 0, ny = 0.16 y
      ADDR_STEM:          w = uw(A_PY,   B_C016, 1'b0, ACC_NOP,   WB_NONE, SEQ_NEXT);
      ADDR_STEM + 6'd1:   w = uw(A_NONE, B_ONE,  1'b0, ACC_CLR,   WB_NONE, SEQ_NEXT);
      ADDR_STEM + 6'd2:   w = uw(A_NONE, B_ONE,  1'b0, ACC_LOAD,  WB_NX,   SEQ_NEXT);
      ADDR_STEM + 6'd3:   w = uw(A_NONE, B_ONE,  1'b0, ACC_NOP,   WB_NY,   SEQ_GOTO);
      // main frond
      ADDR_MAIN:          w = uw(A_PX,   B_C085, 1'b0, ACC_NOP,   WB_NONE, SEQ_NEXT);
      ADDR_MAIN + 6'd1:   w = uw(A_PY,   B_C004, 1'b0, ACC_LOAD,  WB_NONE, SEQ_NEXT);
      ADDR_MAIN + 6'd2:   w = uw(A_PX,   B_C004, 1'b0, ACC_ADD,   WB_NONE, SEQ_NEXT);
      ADDR_MAIN + 6'd3:   w = uw(A_PY,   B_C085, 1'b0, ACC_NLOAD, WB_NX,   SEQ_NEXT);
      ADDR_MAIN + 6'd4:   w = uw(A_ONE,  B_C160, 1'b0, ACC_ADD,   WB_NONE, SEQ_NEXT);
      ADDR_MAIN + 6'd5:   w = uw(A_NONE, B_ONE,  1'b0, ACC_ADD,   WB_NONE, SEQ_NEXT);
      ADDR_MAIN + 6'd6:   w = uw(A_NONE, B_ONE,  1'b0, ACC_NOP,   WB_NY,   SEQ_GOTO);
      // left leaflet
      ADDR_LEFT:          w = uw(A_PX,   B_C020, 1'b0, ACC_NOP,   WB_NONE, SEQ_NEXT);
      ADDR_LEFT + 6'd1:   w = uw(A_PY,   B_C026, 1'b0, ACC_LOAD,  WB_NONE, SEQ_NEXT);
      ADDR_LEFT + 6'd2:   w = uw(A_PX,   B_C023, 1'b0, ACC_SUB,   WB_NONE, SEQ_NEXT);
      ADDR_LEFT + 6'd3:   w = uw(A_PY,   B_C022, 1'b0, ACC_LOAD,  WB_NX,   SEQ_NEXT);
      ADDR_LEFT + 6'd4:   w = uw(A_ONE,  B_C160, 1'b0, ACC_ADD,   WB_NONE, SEQ_NEXT);
      ADDR_LEFT + 6'd5:   w = uw(A_NONE, B_ONE,  1'b0, ACC_ADD,   WB_NONE, SEQ_NEXT);
      ADDR_LEFT + 6'd6:   w = uw(A_NONE, B_ONE,  1'b0, ACC_NOP,   WB_NY,   SEQ_GOTO);
      // right leaflet
      ADDR_RIGHT:         w = uw(A_PX,   B_C015, 1'b0, ACC_NOP,   WB_NONE, SEQ_NEXT);
      ADDR_RIGHT + 6'd1:  w = uw(A_PY,   B_C028, 1'b0, ACC_NLOAD, WB_NONE, SEQ_NEXT);
      ADDR_RIGHT + 6'd2:  w = uw(A_PX,   B_C026, 1'b0, ACC_ADD,   WB_NONE, SEQ_NEXT);
      ADDR_RIGHT + 6'd3:  w = uw(A_PY,   B_C024, 1'b0, ACC_LOAD,  WB_NX,   SEQ_NEXT);
      ADDR_RIGHT + 6'd4:  w = uw(A_ONE,  B_C044, 1'b0, ACC_ADD,   WB_NONE, SEQ_NEXT);
      ADDR_RIGHT + 6'd5:  w = uw(A_NONE, B_ONE,  1'b0, ACC_ADD,   WB_NONE, SEQ_NEXT);
      ADDR_RIGHT + 6'd6:  w = uw(A_NONE, B_ONE,  1'b0, ACC_NOP,   WB_NY,   SEQ_GOTO);
      // pixel mapping, then rotation about the canvas center
      ADDR_PIXEL:         w = uw(A_PX,   B_XSCALE, 1'b0, ACC_NOP,  WB_NONE, SEQ_NEXT);
      ADDR_PIXEL + 6'd1:  w = uw(A_XOFF, B_ONE,    1'b0, ACC_LOAD, WB_NONE, SEQ_NEXT);
      ADDR_PIXEL + 6'd2:  w = uw(A_PY,   B_YSCALE, 1'b0, ACC_ADD,  WB_NONE, SEQ_NEXT);
      ADDR_PIXEL + 6'd3:  w = uw(A_YOFF, B_ONE,    1'b0, ACC_LOAD, WB_DX,   SEQ_NEXT);
      ADDR_PIXEL + 6'd4:  w = uw(A_DXH,  B_COS,    1'b1, ACC_ADD,  WB_NONE, SEQ_NEXT);
      ADDR_PIXEL + 6'd5:  w = uw(A_DXL,  B_COS,    1'b0, ACC_LOAD, WB_DY,   SEQ_NEXT);
      ADDR_PIXEL + 6'd6:  w = uw(A_DYH,  B_SIN,    1'b1, ACC_ADD,  WB_NONE, SEQ_NEXT);
      ADDR_PIXEL + 6'd7:  w = uw(A_DYL,  B_SIN,    1'b0, ACC_SUB,  WB_NONE, SEQ_NEXT);
      ADDR_PIXEL + 6'd8:  w = uw(A_DXH,  B_SIN,    1'b1, ACC_SUB,  WB_NONE, SEQ_NEXT);
      ADDR_PIXEL + 6'd9:  w = uw(A_DXL,  B_SIN,    1'b0, ACC_LOAD, WB_RX,   SEQ_NEXT);
      ADDR_PIXEL + 6'd10: w = uw(A_DYH,  B_COS,    1'b1, ACC_ADD,  WB_NONE, SEQ_NEXT);
      ADDR_PIXEL + 6'd11: w = uw(A_DYL,  B_COS,    1'b0, ACC_ADD,  WB_NONE, SEQ_NEXT);
      ADDR_PIXEL + 6'd12: w = uw(A_NONE, B_ONE,    1'b0, ACC_ADD,  WB_NONE, SEQ_NEXT);
      ADDR_PIXEL + 6'd13: w = uw(A_NONE, B_ONE,    1'b0, ACC_NOP,  WB_NONE, SEQ_DONE);
      default:            w = uw(A_NONE, B_ONE,    1'b0, ACC_NOP,  WB_NONE, SEQ_DONE);
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/barnsley_fern_point_generator.sv */
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+--------------------------------
// in       | input     | in_valid_i / in_stall_o   | rand_pick, restart
// out      | output    | out_valid_o / out_stall_i | pixel_x, pixel_y, in_bounds, color
// cfg      | input     | cfg_we_i                  | cfg_addr_i, cfg_data_i
//
// One point runs one dispatch step, the map routine and 14 pixel and rotation steps of
// the microcode program; each step that selects an operand A issues one product through
// the shared 33x33 multiplier. The result sits in an output register, so a new
// transaction is taken while it waits; a full output register holds the program on
// its last step.
// Reset loads the configuration defaults and puts the point at the origin.
module barnsley_fern_point_generator #(
  parameter int unsigned CANVAS_SIZE = 800
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bfpg_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bfpg_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [bfpg_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [bfpg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bfpg_pkg::*;

  localparam logic [6:0] PICK_MAIN_MAX = 7'd85;
  localparam logic [6:0] PICK_LEFT_MAX = 7'd92;

  cfg_t      cfg_q;
  logic      busy, start, out_ready, out_valid_q;
  pick_cls_e pick_cls;
  seq_ctrl_t ctrl;
  out_item_t result, out_q;

  assign in_stall_o  = busy;
  assign start       = in_valid_i && !busy;
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Classify the pick; anything above the left-leaflet range uses the right-leaflet map
  always_comb begin
    if (in_data_i.rand_pick == 7'd0) begin
      pick_cls = CLS_STEM;
    end else if (in_data_i.rand_pick <= PICK_MAIN_MAX) begin
      pick_cls = CLS_MAIN;
    end else if (in_data_i.rand_pick <= PICK_LEFT_MAX) begin
      pick_cls = CLS_LEFT;
    end else begin
      pick_cls = CLS_RIGHT;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_scale     <= 32'sd2621440;
      cfg_q.x_offset    <= 32'sd23592960;
      cfg_q.y_scale     <= -32'sd2621440;
      cfg_q.y_offset    <= 32'sd28180480;
      cfg_q.cos_term    <= 18'sd46341;
      cfg_q.sin_term    <= 18'sd46341;
      cfg_q.pixel_color <= 24'd4290594;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_X_SCALE:     cfg_q.x_scale     <= cfg_data_i;
        CFG_X_OFFSET:    cfg_q.x_offset    <= cfg_data_i;
        CFG_Y_SCALE:     cfg_q.y_scale     <= cfg_data_i;
        CFG_Y_OFFSET:    cfg_q.y_offset    <= cfg_data_i;
        CFG_COS_TERM:    cfg_q.cos_term    <= cfg_data_i[17:0];
        CFG_SIN_TERM:    cfg_q.sin_term    <= cfg_data_i[17:0];
        CFG_PIXEL_COLOR: cfg_q.pixel_color <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  bfpg_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .pick_cls_i  (pick_cls),
    .out_ready_i (out_ready),
    .busy_o      (busy),
    .ctrl_o      (ctrl)
  );

  bfpg_datapath #(
    .CANVAS_SIZE (CANVAS_SIZE)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .restart_i (in_data_i.restart),
    .ctrl_i    (ctrl),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  // Output register: load on the last step, drop once the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      out_q <= result;
    end
  end

endmodule

/* hw/rtl/bfpg_seq.sv */
module bfpg_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  bfpg_pkg::pick_cls_e   pick_cls_i,
  input  logic                  out_ready_i,
  output logic                  busy_o,
  output bfpg_pkg::seq_ctrl_t   ctrl_o
);
  import bfpg_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  pick_cls_e       cls_q;
  ctrl_word_t      word;
  logic            en;

  assign word = ucode_rom(pc_q);

  // Hold the final step while the output register is still full
  assign en = (state_q == S_RUN) && !((word.seq == SEQ_DONE) && !out_ready_i);

  assign ctrl_o.en   = en;
  assign ctrl_o.done = en && (word.seq == SEQ_DONE);
  assign ctrl_o.word = word;
  assign busy_o      = (state_q == S_RUN);

  // Next step and jumps
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    if (state_q == S_IDLE) begin
      if (start_i) begin
        state_d = S_RUN;
        pc_d    = ADDR_DISPATCH;
      end
    end else if (en) begin
      case (word.seq)
        SEQ_NEXT: pc_d = pc_q + 6'd1;
        SEQ_GOTO: pc_d = word.target;
        SEQ_DISPATCH: begin
          case (cls_q)
            CLS_STEM:  pc_d = ADDR_STEM;
            CLS_MAIN:  pc_d = ADDR_MAIN;
            CLS_LEFT:  pc_d = ADDR_LEFT;
            CLS_RIGHT: pc_d = ADDR_RIGHT;
            default:   pc_d = ADDR_RIGHT;
          endcase
        end
        SEQ_DONE: begin
          state_d = S_IDLE;
          pc_d    = ADDR_DISPATCH;
        end
        default: pc_d = pc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= ADDR_DISPATCH;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // Latch the map choice with the transaction
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == S_IDLE)) begin
      cls_q <= pick_cls_i;
    end
  end

endmodule

/* hw/rtl/bfpg_datapath.sv */
module bfpg_datapath #(
  parameter int unsigned CANVAS_SIZE = 800
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  restart_i,
  input  bfpg_pkg::seq_ctrl_t   ctrl_i,
  input  bfpg_pkg::cfg_t        cfg_i,
  output bfpg_pkg::out_item_t   result_o
);
  import bfpg_pkg::*;

  localparam int unsigned ACC_W = 66;
  localparam int unsigned PIX_W = 42;
  localparam int unsigned ROT_W = 44;

  localparam logic signed [PIX_W-1:0] CENTER_PIX = PIX_W'((CANVAS_SIZE / 2) * 65536);
  localparam logic signed [ROT_W-1:0] CENTER_ROT = ROT_W'((CANVAS_SIZE / 2) * 65536);
  localparam logic signed [ROT_W-1:0] LIMIT_ROT  = ROT_W'(CANVAS_SIZE * 65536);

  logic signed [31:0]       point_x_q, point_y_q, tmp_x_q;
  logic signed [PIX_W-1:0]  dx_q, dy_q;
  logic signed [ROT_W-1:0]  rx_q, ry;
  logic signed [ACC_W-1:0]  prod_q, acc_q, acc_d, prod_full;
  logic signed [32:0]       a_op, b_op;
  logic signed [PIX_W-1:0]  acc_q24;
  logic signed [31:0]       acc_sat;
  logic                     ok;
  ctrl_word_t               w;

  assign w = ctrl_i.word;

  function automatic logic signed [31:0] sat_q24(input logic signed [PIX_W-1:0] v);
    if (v > 42'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -42'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Operand A select
  always_comb begin
    case (w.a_sel)
      A_PX:    a_op = {point_x_q[31], point_x_q};
      A_PY:    a_op = {point_y_q[31], point_y_q};
      A_XOFF:  a_op = {cfg_i.x_offset[31], cfg_i.x_offset};
      A_YOFF:  a_op = {cfg_i.y_offset[31], cfg_i.y_offset};
      A_ONE:   a_op = K_ONE;
      A_DXH:   a_op = {{15{dx_q[PIX_W-1]}}, dx_q[PIX_W-1:24]};
      A_DXL:   a_op = {9'd0, dx_q[23:0]};
      A_DYH:   a_op = {{15{dy_q[PIX_W-1]}}, dy_q[PIX_W-1:24]};
      A_DYL:   a_op = {9'd0, dy_q[23:0]};
      default: a_op = '0;
    endcase
  end

  // Operand B select
  always_comb begin
    case (w.b_sel)
      B_C016:   b_op = C016;
      B_C085:   b_op = C085;
      B_C004:   b_op = C004;
      B_C160:   b_op = C160;
      B_C020:   b_op = C020;
      B_C026:   b_op = C026;
      B_C023:   b_op = C023;
      B_C022:   b_op = C022;
      B_C015:   b_op = C015;
      B_C028:   b_op = C028;
      B_C024:   b_op = C024;
      B_C044:   b_op = C044;
      B_ONE:    b_op = K_ONE;
      B_XSCALE: b_op = {cfg_i.x_scale[31], cfg_i.x_scale};
      B_YSCALE: b_op = {cfg_i.y_scale[31], cfg_i.y_scale};
      B_COS:    b_op = {{15{cfg_i.cos_term[17]}}, cfg_i.cos_term};
      B_SIN:    b_op = {{15{cfg_i.sin_term[17]}}, cfg_i.sin_term};
      default:  b_op = '0;
    endcase
  end

  assign prod_full = a_op * b_op;

  // Accumulate the product issued in the previous step
  always_comb begin
    case (w.acc_op)
      ACC_NOP:   acc_d = acc_q;
      ACC_LOAD:  acc_d = prod_q;
      ACC_NLOAD: acc_d = -prod_q;
      ACC_ADD:   acc_d = acc_q + prod_q;
      ACC_SUB:   acc_d = acc_q - prod_q;
      ACC_CLR:   acc_d = '0;
      default:   acc_d = acc_q;
    endcase
  end

  assign acc_q24 = $signed(acc_q[ACC_W-1:24]);
  assign acc_sat = sat_q24(acc_q24);

  // Shared multiplier, accumulator and scratch registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      if (w.a_sel != A_NONE) begin
        prod_q <= w.shift24 ? (prod_full <<< 24) : prod_full;
      end
      acc_q <= acc_d;
      case (w.wb)
        WB_NX:   tmp_x_q <= acc_sat;
        WB_DX:   dx_q    <= acc_q24 - CENTER_PIX;
        WB_DY:   dy_q    <= acc_q24 - CENTER_PIX;
        WB_RX:   rx_q    <= $signed(acc_q[59:16]) + CENTER_ROT;
        default: ;
      endcase
    end
  end

  // Fractal point: restart clears it, the map commits both coordinates at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q <= '0;
      point_y_q <= '0;
    end else if (start_i && restart_i) begin
      point_x_q <= '0;
      point_y_q <= '0;
    end else if (ctrl_i.en && (w.wb == WB_NY)) begin
      point_x_q <= tmp_x_q;
      point_y_q <= acc_sat;
    end
  end

  // Result from the last rotation sum
  assign ry = $signed(acc_q[59:16]) + CENTER_ROT;
  assign ok = !rx_q[ROT_W-1] && !ry[ROT_W-1] && (rx_q < LIMIT_ROT) && (ry < LIMIT_ROT);

  assign result_o.pixel_x   = ok ? rx_q[27:16] : 12'd0;
  assign result_o.pixel_y   = ok ? ry[27:16] : 12'd0;
  assign result_o.in_bounds = ok;
  assign result_o.color_out = cfg_i.pixel_color;

endmodule

/* hw/rtl/bfpg_checker.sv */
module bfpg_checker #(
  parameter int unsigned CANVAS_SIZE = 800
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input bfpg_pkg::out_item_t                 out_data_o
);
  import bfpg_pkg::*;

  localparam logic [11:0] CANVAS_PIX = 12'(CANVAS_SIZE - 1);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The program runs after every accepted transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block idle right after accepting a transaction");

  // Off-canvas points carry zero coordinates
  a_off_canvas_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_bounds |-> (out_data_o.pixel_x == 12'd0)
                                          && (out_data_o.pixel_y == 12'd0))
    else $error("off-canvas result with nonzero coordinates");

  // Plotted points lie inside the canvas
  a_on_canvas_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.in_bounds |-> (out_data_o.pixel_x <= CANVAS_PIX)
                                         && (out_data_o.pixel_y <= CANVAS_PIX))
    else $error("plotted point outside canvas");

endmodule

bind barnsley_fern_point_generator bfpg_checker #(
  .CANVAS_SIZE (CANVAS_SIZE)
) u_bfpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
